// ===== rtl/vtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vtt_pkg
// Shared types, register codes and helpers for the velocity twist transform.
// ---------------------------------------------------------------------------
package vtt_pkg;

  // Register file geometry: four 48-bit registers on an 8-byte stride.
  localparam int REG_W   = 48;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 5;
  localparam int ELEM_W  = 16;

  // Datapath widths.
  localparam int PROD_W  = 2 * ELEM_W;        // Q2.14 x Q8.8 product
  localparam int SUM_W   = PROD_W + 2;        // sum of three products
  localparam int ROT_FRAC = 14;
  localparam int RW_W    = SUM_W - ROT_FRAC;  // rotated component
  localparam int XP_W    = ELEM_W + RW_W;     // t x rw partial product
  localparam int XD_W    = XP_W + 1;          // difference of two partials
  localparam int TR_FRAC = 8;
  localparam int CX_W    = XD_W - TR_FRAC;    // cross product term
  localparam int ACC_W   = CX_W + 1;          // final linear sum

  // Register codes (paddr[4:3]).
  typedef enum logic [1:0] {
    REG_ROT_ROW0  = 2'd0,
    REG_ROT_ROW1  = 2'd1,
    REG_ROT_ROW2  = 2'd2,
    REG_TRANS_VEC = 2'd3
  } reg_code_t;

  // Reset values: identity rotation, zero translation.
  localparam logic [REG_W-1:0] ROT_ROW0_RST  = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] ROT_ROW1_RST  = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] ROT_ROW2_RST  = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] TRANS_VEC_RST = 48'h0000_0000_0000;

  // Per-lane pipeline load enables.
  typedef struct packed {
    logic s1;
    logic s2;
  } lane_en_t;

  // Saturated component and its clip flag.
  typedef struct packed {
    logic              flag;
    logic [ELEM_W-1:0] val;
  } sat_t;

  // Clip a wide signed value to 16 bits.
  function automatic sat_t sat16(input logic signed [ACC_W-1:0] x);
    sat_t r;
    if (x > $signed(ACC_W'(32767))) begin
      r.flag = 1'b1;
      r.val  = 16'h7fff;
    end else if (x < -$signed(ACC_W'(32768))) begin
      r.flag = 1'b1;
      r.val  = 16'h8000;
    end else begin
      r.flag = 1'b0;
      r.val  = x[ELEM_W-1:0];
    end
    return r;
  endfunction

endpackage : vtt_pkg
`default_nettype wire

// ===== rtl/velocity_twist_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// velocity_twist_transform
// Maps a twist (v, w) through [R, skew(t)R; 0, R] in Q8.8 fixed point.
// ---------------------------------------------------------------------------
// Usage:
// - Input channel: in_valid/in_ready carry one twist item (lin_*, ang_*).
// - Output channel: out_valid/out_ready carry the transformed item and
//   the saturated flag, one result per input item, in order.
// - Configuration: APB port, 64-bit data, registers rot_row0, rot_row1,
//   rot_row2 and trans_vec at byte addresses 0, 8, 16 and 24. Write them
//   only while no item is in flight.
// - Throughput: one item per cycle while the output is not stalled. Three
//   row lanes each form one row of R v and R w in parallel, then a cross
//   product stage and a merge stage, with four pipeline registers: lane
//   products, lane row sums, cross product partials and the output.
// - Stalls: each stage holds its item while the next one is full, so the
//   pipeline keeps filling while a finished result waits; in_ready drops
//   only once every stage is occupied.
// - Reset: rst empties the pipeline and sets R to identity and t to zero.
// ---------------------------------------------------------------------------
module velocity_twist_transform (
  input  wire                              clk,
  input  wire                              rst,
  // APB configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [vtt_pkg::ADDR_W-1:0]       paddr,
  input  wire  [vtt_pkg::DATA_W-1:0]       pwdata,
  output logic [vtt_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  // Input channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  signed [15:0]               lin_x,
  input  wire  signed [15:0]               lin_y,
  input  wire  signed [15:0]               lin_z,
  input  wire  signed [15:0]               ang_x,
  input  wire  signed [15:0]               ang_y,
  input  wire  signed [15:0]               ang_z,
  // Output channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [15:0]               out_lin_x,
  output logic signed [15:0]               out_lin_y,
  output logic signed [15:0]               out_lin_z,
  output logic signed [15:0]               out_ang_x,
  output logic signed [15:0]               out_ang_y,
  output logic signed [15:0]               out_ang_z,
  output logic                             saturated
);
  import vtt_pkg::*;

  logic [REG_W-1:0] rot_row0;
  logic [REG_W-1:0] rot_row1;
  logic [REG_W-1:0] rot_row2;
  logic [REG_W-1:0] trans_vec;
  logic [REG_W-1:0] rows [3];
  reg_code_t        reg_sel;
  logic             reg_wr;

  logic [REG_W-1:0] vel_lin;
  logic [REG_W-1:0] vel_ang;

  logic             v1, v2, v3;
  logic             rdy1, rdy2, rdy3, rdy4;
  lane_en_t         lane_en;
  logic             en3, en4;

  logic signed [RW_W-1:0] rv [3];
  logic signed [RW_W-1:0] rw [3];
  logic signed [RW_W-1:0] rv_d [3];
  logic signed [RW_W-1:0] rw_d [3];
  logic signed [XP_W-1:0] xp_a [3];
  logic signed [XP_W-1:0] xp_b [3];
  logic [ELEM_W-1:0]      lin_o [3];
  logic [ELEM_W-1:0]      ang_o [3];

  // Register decode.
  assign pready  = 1'b1;
  assign reg_sel = reg_code_t'(paddr[ADDR_W-1:3]);
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0  <= ROT_ROW0_RST;
      rot_row1  <= ROT_ROW1_RST;
      rot_row2  <= ROT_ROW2_RST;
      trans_vec <= TRANS_VEC_RST;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_ROT_ROW0:  rot_row0  <= pwdata[REG_W-1:0];
        REG_ROT_ROW1:  rot_row1  <= pwdata[REG_W-1:0];
        REG_ROT_ROW2:  rot_row2  <= pwdata[REG_W-1:0];
        REG_TRANS_VEC: trans_vec <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_ROT_ROW0:  prdata = DATA_W'(rot_row0);
      REG_ROT_ROW1:  prdata = DATA_W'(rot_row1);
      REG_ROT_ROW2:  prdata = DATA_W'(rot_row2);
      REG_TRANS_VEC: prdata = DATA_W'(trans_vec);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage loads when it is empty or drains.
  always_comb begin
    rdy4       = !out_valid || out_ready;
    rdy3       = !v3 || rdy4;
    rdy2       = !v2 || rdy3;
    rdy1       = !v1 || rdy2;
    in_ready   = rdy1;
    lane_en.s1 = rdy1 && in_valid;
    lane_en.s2 = rdy2 && v1;
    en3        = rdy3 && v2;
    en4        = rdy4 && v3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  // Pack the incoming item for the lanes.
  assign vel_lin = {lin_z, lin_y, lin_x};
  assign vel_ang = {ang_z, ang_y, ang_x};
  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;

  // One lane per rotation row.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    vtt_lane u_lane (
      .clk     (clk),
      .en      (lane_en),
      .row     (rows[i]),
      .vel_lin (vel_lin),
      .vel_ang (vel_ang),
      .rv      (rv[i]),
      .rw      (rw[i])
    );
  end

  vtt_cross u_cross (
    .clk    (clk),
    .en     (en3),
    .trans  (trans_vec),
    .rv_in  (rv),
    .rw_in  (rw),
    .xp_a   (xp_a),
    .xp_b   (xp_b),
    .rv_out (rv_d),
    .rw_out (rw_d)
  );

  vtt_merge u_merge (
    .clk      (clk),
    .en       (en4),
    .xp_a     (xp_a),
    .xp_b     (xp_b),
    .rv       (rv_d),
    .rw       (rw_d),
    .lin      (lin_o),
    .ang      (ang_o),
    .sat_flag (saturated)
  );

  assign out_lin_x = $signed(lin_o[0]);
  assign out_lin_y = $signed(lin_o[1]);
  assign out_lin_z = $signed(lin_o[2]);
  assign out_ang_x = $signed(ang_o[0]);
  assign out_ang_y = $signed(ang_o[1]);
  assign out_ang_z = $signed(ang_o[2]);

endmodule : velocity_twist_transform
`default_nettype wire

// ===== rtl/vtt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vtt_lane
// One rotation row: forms R[i] . v and R[i] . w over two pipeline stages.
// ---------------------------------------------------------------------------
module vtt_lane (
  input  wire                               clk,
  input  wire        vtt_pkg::lane_en_t     en,
  input  wire        [vtt_pkg::REG_W-1:0]   row,
  input  wire        [vtt_pkg::REG_W-1:0]   vel_lin,
  input  wire        [vtt_pkg::REG_W-1:0]   vel_ang,
  output logic signed [vtt_pkg::RW_W-1:0]   rv,
  output logic signed [vtt_pkg::RW_W-1:0]   rw
);
  import vtt_pkg::*;

  logic signed [PROD_W-1:0] pv [3];
  logic signed [PROD_W-1:0] pw [3];
  logic signed [SUM_W-1:0]  sum_v;
  logic signed [SUM_W-1:0]  sum_w;

  // Stage 1: the six element products of this row.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int j = 0; j < 3; j++) begin
        pv[j] <= $signed(row[ELEM_W*j +: ELEM_W]) * $signed(vel_lin[ELEM_W*j +: ELEM_W]);
        pw[j] <= $signed(row[ELEM_W*j +: ELEM_W]) * $signed(vel_ang[ELEM_W*j +: ELEM_W]);
      end
    end
  end

  // Sum the products at full width.
  always_comb begin
    sum_v = SUM_W'(pv[0]) + SUM_W'(pv[1]) + SUM_W'(pv[2]);
    sum_w = SUM_W'(pw[0]) + SUM_W'(pw[1]) + SUM_W'(pw[2]);
  end

  // Stage 2: drop the rotation fraction bits (floor).
  always_ff @(posedge clk) begin
    if (en.s2) begin
      rv <= sum_v[SUM_W-1:ROT_FRAC];
      rw <= sum_w[SUM_W-1:ROT_FRAC];
    end
  end

endmodule : vtt_lane
`default_nettype wire

// ===== rtl/vtt_cross.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vtt_cross
// Partial products of t x (R w), registered along with R v and R w.
// ---------------------------------------------------------------------------
module vtt_cross (
  input  wire                               clk,
  input  wire                               en,
  input  wire        [vtt_pkg::REG_W-1:0]   trans,
  input  wire signed [vtt_pkg::RW_W-1:0]    rv_in [3],
  input  wire signed [vtt_pkg::RW_W-1:0]    rw_in [3],
  output logic signed [vtt_pkg::XP_W-1:0]   xp_a [3],
  output logic signed [vtt_pkg::XP_W-1:0]   xp_b [3],
  output logic signed [vtt_pkg::RW_W-1:0]   rv_out [3],
  output logic signed [vtt_pkg::RW_W-1:0]   rw_out [3]
);
  import vtt_pkg::*;

  logic signed [ELEM_W-1:0] t [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k] = $signed(trans[ELEM_W*k +: ELEM_W]);
    end
  end

  // Component i of the cross product is xp_a[i] - xp_b[i].
  always_ff @(posedge clk) begin
    if (en) begin
      xp_a[0] <= t[1] * rw_in[2];
      xp_b[0] <= t[2] * rw_in[1];
      xp_a[1] <= t[2] * rw_in[0];
      xp_b[1] <= t[0] * rw_in[2];
      xp_a[2] <= t[0] * rw_in[1];
      xp_b[2] <= t[1] * rw_in[0];
      rv_out  <= rv_in;
      rw_out  <= rw_in;
    end
  end

endmodule : vtt_cross
`default_nettype wire

// ===== rtl/vtt_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vtt_merge
// Combines the lane results: adds the cross term, saturates, sets the flag.
// ---------------------------------------------------------------------------
module vtt_merge (
  input  wire                                clk,
  input  wire                                en,
  input  wire signed [vtt_pkg::XP_W-1:0]     xp_a [3],
  input  wire signed [vtt_pkg::XP_W-1:0]     xp_b [3],
  input  wire signed [vtt_pkg::RW_W-1:0]     rv [3],
  input  wire signed [vtt_pkg::RW_W-1:0]     rw [3],
  output logic       [vtt_pkg::ELEM_W-1:0]   lin [3],
  output logic       [vtt_pkg::ELEM_W-1:0]   ang [3],
  output logic                               sat_flag
);
  import vtt_pkg::*;

  logic signed [XD_W-1:0]  diff [3];
  logic signed [CX_W-1:0]  cx   [3];
  logic signed [ACC_W-1:0] acc  [3];
  sat_t                    s_lin [3];
  sat_t                    s_ang [3];
  logic                    any_sat;

  // Cross term with floor shift, then linear sum and clipping.
  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff[i]  = XD_W'(xp_a[i]) - XD_W'(xp_b[i]);
      cx[i]    = diff[i][XD_W-1:TR_FRAC];
      acc[i]   = ACC_W'(rv[i]) + ACC_W'(cx[i]);
      s_lin[i] = sat16(acc[i]);
      s_ang[i] = sat16(ACC_W'(rw[i]));
      any_sat  = any_sat | s_lin[i].flag | s_ang[i].flag;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lin[i] <= s_lin[i].val;
        ang[i] <= s_ang[i].val;
      end
      sat_flag <= any_sat;
    end
  end

endmodule : vtt_merge
`default_nettype wire

// ===== sim/velocity_twist_transform_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// velocity_twist_transform_test
// Self-checking bench for the velocity twist transform. Twist items go in
// through the valid/ready input channel, and the rotation and translation
// are loaded over the APB port while the pipeline is empty. A fixed-point
// model of R v + t x (R w) and R w predicts every result, and each result
// is compared field by field against the oldest prediction. Both channels
// idle and stall at random in the first two of three random phases.
// ---------------------------------------------------------------------------
module velocity_twist_transform_test;
  import vtt_pkg::*;

  localparam int  HALF_PERIOD = 6;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  CYCLE_LIMIT = 300000;

  // A twist or a transformed twist: lin x,y,z then ang x,y,z.
  typedef logic [15:0] twist_vec_t [6];

  typedef struct {
    logic [15:0] comp [6];
    logic        sat;
  } twist_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [15:0]  lin_x = '0;
  logic signed [15:0]  lin_y = '0;
  logic signed [15:0]  lin_z = '0;
  logic signed [15:0]  ang_x = '0;
  logic signed [15:0]  ang_y = '0;
  logic signed [15:0]  ang_z = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [15:0]  out_lin_x;
  logic signed [15:0]  out_lin_y;
  logic signed [15:0]  out_lin_z;
  logic signed [15:0]  out_ang_x;
  logic signed [15:0]  out_ang_y;
  logic signed [15:0]  out_ang_z;
  logic                saturated;

  // Shadow copy of the register file, kept in step with every write.
  logic [REG_W-1:0]    rot_rows [3] = '{ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST};
  logic [REG_W-1:0]    trans_xyz = TRANS_VEC_RST;

  twist_result_t       pending_twists [$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  velocity_twist_transform DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lin_x     (lin_x),
    .lin_y     (lin_y),
    .lin_z     (lin_z),
    .ang_x     (ang_x),
    .ang_y     (ang_y),
    .ang_z     (ang_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_lin_x (out_lin_x),
    .out_lin_y (out_lin_y),
    .out_lin_z (out_lin_z),
    .out_ang_x (out_ang_x),
    .out_ang_y (out_ang_y),
    .out_ang_z (out_ang_z),
    .saturated (saturated)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Clip a wide value to 16 bits; the top bit flags a clip.
  function automatic logic [16:0] clip16(longint x);
    if (x > 32767) return {1'b1, 16'h7fff};
    if (x < -32768) return {1'b1, 16'h8000};
    return {1'b0, x[15:0]};
  endfunction

  // Predict the transformed twist from the shadow registers.
  function automatic twist_result_t transform_twist(twist_vec_t tw);
    longint        rot [3][3];
    longint        tr [3];
    longint        vel [6];
    longint        rv [3];
    longint        rw [3];
    longint        cx;
    logic [16:0]   clipped;
    twist_result_t res;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = longint'($signed(rot_rows[i][16*j +: 16]));
      end
      tr[i] = longint'($signed(trans_xyz[16*i +: 16]));
    end
    for (int k = 0; k < 6; k++) begin
      vel[k] = longint'($signed(tw[k]));
    end
    // Rotate both halves; the arithmetic shift rounds toward minus infinity.
    for (int i = 0; i < 3; i++) begin
      rv[i] = 0;
      rw[i] = 0;
      for (int j = 0; j < 3; j++) begin
        rv[i] += rot[i][j] * vel[j];
        rw[i] += rot[i][j] * vel[j + 3];
      end
      rv[i] = rv[i] >>> ROT_FRAC;
      rw[i] = rw[i] >>> ROT_FRAC;
    end
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cx = (tr[(i + 1) % 3] * rw[(i + 2) % 3] - tr[(i + 2) % 3] * rw[(i + 1) % 3]) >>> TR_FRAC;
      clipped = clip16(rv[i] + cx);
      res.comp[i] = clipped[15:0];
      res.sat |= clipped[16];
      clipped = clip16(rw[i]);
      res.comp[i + 3] = clipped[15:0];
      res.sat |= clipped[16];
    end
    return res;
  endfunction

  // Offer one twist item, idling first at the sender rate, and record its
  // prediction when it is taken.
  task automatic send_twist(twist_vec_t tw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    lin_x <= tw[0];
    lin_y <= tw[1];
    lin_z <= tw[2];
    ang_x <= tw[3];
    ang_y <= tw[4];
    ang_z <= tw[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_twists.push_back(transform_twist(tw));
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty before touching registers.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_twists.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write followed by a read-back of the same register. The upper data
  // bits carry junk, which the register must drop.
  task automatic write_reg(reg_code_t code, logic [REG_W-1:0] value);
    logic [DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {code, 3'b000};
    pwdata <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (code == REG_TRANS_VEC) trans_xyz = value;
    else rot_rows[int'(code)] = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = {{(DATA_W - REG_W){1'b0}}, value};
    if (prdata !== want) begin
      $display("%0t: read-back of %s expected %h got %h", $time, code.name(), want, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_transform(logic [REG_W-1:0] r0, logic [REG_W-1:0] r1,
                                logic [REG_W-1:0] r2, logic [REG_W-1:0] t);
    write_reg(REG_ROT_ROW0, r0);
    write_reg(REG_ROT_ROW1, r1);
    write_reg(REG_ROT_ROW2, r2);
    write_reg(REG_TRANS_VEC, t);
  endtask

  // Velocity values: full range, small magnitudes and the edges.
  function automatic logic [15:0] rand_velocity();
    logic [15:0] edges [5] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
    case ($urandom_range(3))
      0, 1: return 16'($urandom);
      2: return 16'($urandom_range(1023)) - 16'd512;
      default: return edges[$urandom_range(4)];
    endcase
  endfunction

  // Rotation entries: full range, within one in magnitude, small values and the edges.
  function automatic logic [15:0] rand_rot_entry();
    logic [15:0] edges [5] = '{16'h7fff, 16'h8000, 16'h0000, 16'h4000, 16'hc000};
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32768)) - 16'h4000;
      2: return edges[$urandom_range(4)];
      default: return 16'($urandom_range(511)) - 16'd256;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_triplet(bit is_rot);
    logic [REG_W-1:0] packed_val;
    for (int k = 0; k < 3; k++) begin
      packed_val[16*k +: 16] = is_rot ? rand_rot_entry() : rand_velocity();
    end
    return packed_val;
  endfunction

  function automatic twist_vec_t rand_twist();
    twist_vec_t tw;
    for (int k = 0; k < 6; k++) tw[k] = rand_velocity();
    return tw;
  endfunction

  // Reset values: identity rotation and zero translation pass a twist through.
  task automatic test_reset_identity();
    send_twist('{default: 16'h0000});
    send_twist('{default: 16'h7fff});
    send_twist('{default: 16'h8000});
    send_twist('{16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff});
    send_twist('{default: 16'h5555});
    send_twist('{default: 16'haaaa});
    send_twist('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000});
    drain_pipeline();
  endtask

  // Largest and smallest register contents, a zero rotation and a true
  // quarter turn about z with an offset.
  task automatic test_extreme_config();
    load_transform({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
    send_twist('{default: 16'h7fff});
    send_twist('{default: 16'h8000});
    send_twist('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    drain_pipeline();
    load_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_twist('{default: 16'h7fff});
    send_twist('{default: 16'h8000});
    send_twist('{16'h0100, 16'hff00, 16'h0080, 16'h0100, 16'hff00, 16'h0080});
    drain_pipeline();
    load_transform('0, '0, '0, {16'h0300, 16'hfe00, 16'h0100});
    send_twist('{default: 16'h7fff});
    send_twist('{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600});
    drain_pipeline();
    // Rows (0,-1,0), (1,0,0), (0,0,1); t = (1.0, 2.0, -0.5).
    load_transform({16'h0000, 16'hc000, 16'h0000}, {16'h0000, 16'h0000, 16'h4000},
                   {16'h4000, 16'h0000, 16'h0000}, {16'hff80, 16'h0200, 16'h0100});
    send_twist('{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100});
    send_twist('{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'h0300});
    send_twist('{16'hfc00, 16'h0333, 16'h0080, 16'hff00, 16'h0040, 16'hffc0});
    drain_pipeline();
  endtask

  // Random twists in bursts, with a fresh random transform before each.
  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    int remaining;
    int burst;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    remaining = count;
    while (remaining > 0) begin
      load_transform(rand_triplet(1'b1), rand_triplet(1'b1), rand_triplet(1'b1),
                     rand_triplet(1'b0));
      burst = $urandom_range(40, 90);
      if (burst > remaining) burst = remaining;
      repeat (burst) send_twist(rand_twist());
      remaining -= burst;
      drain_pipeline();
    end
  endtask

  // The receiver stalls at its current rate, decided once per cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    twist_result_t want;
    logic [15:0]   got [6];
    string         names [6];
    names = '{"out_lin_x", "out_lin_y", "out_lin_z", "out_ang_x", "out_ang_y", "out_ang_z"};
    if (!rst && out_valid && out_ready) begin
      got = '{out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z};
      if (pending_twists.size() == 0) begin
        $display("%0t: unexpected item, expected none got %h %h %h %h %h %h %b", $time,
                 got[0], got[1], got[2], got[3], got[4], got[5], saturated);
        error_count++;
      end else begin
        want = pending_twists.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (got[k] !== want.comp[k]) begin
            $display("%0t: %s expected %h got %h", $time, names[k], want.comp[k], got[k]);
            error_count++;
          end
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, saturated);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_identity();
    test_extreme_config();
    test_random_traffic(430, 36, 68);
    test_random_traffic(430, 68, 36);
    test_random_traffic(420, 0, 0);
    drain_pipeline();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
